@@ rtl/nwdp_pkg.sv @@
// Shared types and constants for the nibble-weight dot product block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package nwdp_pkg;

  // Lane count and field widths of one input beat.
  localparam int LANES      = 8;
  localparam int ACT_BITS   = 16;
  localparam int NIB_BITS   = 4;
  localparam int WORD_BITS  = LANES * NIB_BITS;

  // A centered weight 2q-15 fits in a signed value one bit wider than the nibble.
  localparam int WGT_BITS      = NIB_BITS + 1;
  localparam int WEIGHT_OFFSET = (1 << NIB_BITS) - 1;

  // Per-lane product, lane tree sum and running accumulator widths.
  localparam int PROD_BITS = ACT_BITS + WGT_BITS;
  localparam int TREE_BITS = PROD_BITS + $clog2(LANES);
  localparam int SUM_BITS  = 48;

  // Scale register (unsigned Q4.12) and the final shift (12 fraction bits plus the factor 2).
  localparam int                SCALE_BITS  = 16;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(4096);
  localparam int                SCALE_SHIFT = 13;

  // Result width and the split of the magnitude into two partial products.
  localparam int OUT_BITS  = 32;
  localparam int LO_BITS   = OUT_BITS + SCALE_BITS;
  localparam int HI_IN     = SUM_BITS - OUT_BITS;
  localparam int HI_BITS   = HI_IN + SCALE_BITS;
  localparam int QT_BITS   = LO_BITS - SCALE_SHIFT + 1;

  // Stream payload widths.
  localparam int IN_TDATA_BITS  = LANES * ACT_BITS + WORD_BITS;
  localparam int OUT_TDATA_BITS = OUT_BITS;

  typedef logic signed [ACT_BITS-1:0]  act_t;
  typedef logic        [NIB_BITS-1:0]  nib_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;
  typedef logic        [SCALE_BITS-1:0] scale_t;

  // A finished accumulator on its way to the scaling pipeline.
  typedef struct packed {
    logic valid;
    sum_t sum;
  } sum_beat_t;

endpackage

@@ rtl/nwdp_lane.sv @@
// One lane: multiplies a signed activation by its centered 4-bit weight.
// Depends on nwdp_pkg.
`timescale 1ns / 1ps

module nwdp_lane (
  input  nwdp_pkg::act_t  act_i,
  input  nwdp_pkg::nib_t  nib_i,
  output nwdp_pkg::prod_t prod_o
);
  import nwdp_pkg::*;

  logic signed [WGT_BITS-1:0] wgt;

  // Centered weight 2q - 15, always odd and within -15..15. The 5-bit
  // difference wraps straight into its two's complement pattern.
  assign wgt = {nib_i, 1'b0} - WGT_BITS'(WEIGHT_OFFSET);

  assign prod_o = PROD_BITS'(act_i * wgt);

endmodule

@@ rtl/nwdp_merge.sv @@
// Merging stage: adds the lane products into the running sum and hands the
// finished sum of a run to the scaling pipeline. Depends on nwdp_pkg.
`timescale 1ns / 1ps

module nwdp_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nwdp_pkg::prod_t     prod_i [nwdp_pkg::LANES],
  input  logic                valid_i,
  input  logic                last_i,
  output logic                fire_o,
  output nwdp_pkg::sum_beat_t beat_o,
  input  logic                ready_i
);
  import nwdp_pkg::*;

  logic signed [TREE_BITS-1:0] tree;
  sum_t                        acc_q, acc_d;
  sum_t                        total;
  logic                        out_valid_q;
  sum_t                        out_sum_q;
  logic                        out_rdy;

  // Sum of the lane products, then added to the accumulator with wrap-around.
  always_comb begin
    tree = '0;
    for (int j = 0; j < LANES; j++) begin
      tree = tree + TREE_BITS'(prod_i[j]);
    end
    total = acc_q + SUM_BITS'(tree);
  end

  // A beat that ends a run needs room downstream; others are absorbed here.
  assign out_rdy = !out_valid_q || ready_i;
  assign fire_o  = valid_i && (!last_i || out_rdy);

  always_comb begin
    acc_d = acc_q;
    if (fire_o) begin
      acc_d = last_i ? '0 : total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (out_rdy) begin
        out_valid_q <= fire_o && last_i;
      end
    end
  end

  // Finished sum register.
  always_ff @(posedge clk_i) begin
    if (out_rdy && fire_o && last_i) begin
      out_sum_q <= total;
    end
  end

  assign beat_o.valid = out_valid_q;
  assign beat_o.sum   = out_sum_q;

endmodule

@@ rtl/nwdp_scale.sv @@
// Scaling pipeline: magnitude, two partial products with the Q4.12 scale,
// floor shift by 13 and saturation to 32 bits. Depends on nwdp_pkg.
`timescale 1ns / 1ps

module nwdp_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nwdp_pkg::scale_t       scale_i,
  input  nwdp_pkg::sum_beat_t    beat_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output logic [nwdp_pkg::OUT_BITS-1:0] value_o,
  output logic                   sat_o,
  input  logic                   ready_i
);
  import nwdp_pkg::*;

  localparam logic [QT_BITS-1:0] NEG_LIMIT = QT_BITS'(1) << (OUT_BITS - 1);
  localparam logic [QT_BITS-1:0] POS_LIMIT = NEG_LIMIT - QT_BITS'(1);

  // Magnitude stage.
  logic                c_valid_q, c_neg_q, c_rdy;
  logic [SUM_BITS-1:0] c_mag_q;
  // Partial product stage.
  logic                d_valid_q, d_neg_q, d_rdy;
  logic [LO_BITS-1:0]  d_lo_q;
  logic [HI_BITS-1:0]  d_hi_q;
  // Output register.
  logic                o_valid_q, o_rdy;
  logic [OUT_BITS-1:0] o_value_q, o_value_d;
  logic                o_sat_q, o_sat_d;

  logic                hi_over;
  logic [QT_BITS-1:0]  qt_base, qt;

  assign o_rdy   = !o_valid_q || ready_i;
  assign d_rdy   = !d_valid_q || o_rdy;
  assign c_rdy   = !c_valid_q || d_rdy;
  assign ready_o = c_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (c_rdy) c_valid_q <= beat_i.valid;
      if (d_rdy) d_valid_q <= c_valid_q;
      if (o_rdy) o_valid_q <= d_valid_q;
    end
  end

  // Sign and magnitude of the finished sum.
  always_ff @(posedge clk_i) begin
    if (c_rdy && beat_i.valid) begin
      c_neg_q <= beat_i.sum[SUM_BITS-1];
      c_mag_q <= beat_i.sum[SUM_BITS-1] ? SUM_BITS'(-beat_i.sum) : SUM_BITS'(beat_i.sum);
    end
  end

  // Low and high partial products of the magnitude with the scale.
  always_ff @(posedge clk_i) begin
    if (d_rdy && c_valid_q) begin
      d_neg_q <= c_neg_q;
      d_lo_q  <= LO_BITS'(c_mag_q[OUT_BITS-1:0] * scale_i);
      d_hi_q  <= HI_BITS'(c_mag_q[SUM_BITS-1:OUT_BITS] * scale_i);
    end
  end

  // Recombine, shift down, round toward minus infinity for negative sums, clip.
  always_comb begin
    hi_over = |d_hi_q[HI_BITS-1:SCALE_SHIFT];
    qt_base = (QT_BITS'(d_hi_q[SCALE_SHIFT-1:0]) << (OUT_BITS - SCALE_SHIFT))
            + QT_BITS'(d_lo_q[LO_BITS-1:SCALE_SHIFT]);
    qt      = qt_base;
    o_sat_d = 1'b0;
    if (d_neg_q) begin
      qt = qt_base + QT_BITS'(|d_lo_q[SCALE_SHIFT-1:0]);
    end
    if (hi_over) begin
      o_sat_d   = 1'b1;
      o_value_d = d_neg_q ? OUT_BITS'(NEG_LIMIT) : OUT_BITS'(POS_LIMIT);
    end else if (d_neg_q) begin
      if (qt > NEG_LIMIT) begin
        o_sat_d   = 1'b1;
        o_value_d = OUT_BITS'(NEG_LIMIT);
      end else begin
        o_value_d = OUT_BITS'(-qt);
      end
    end else begin
      if (qt > POS_LIMIT) begin
        o_sat_d   = 1'b1;
        o_value_d = OUT_BITS'(POS_LIMIT);
      end else begin
        o_value_d = OUT_BITS'(qt);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy && d_valid_q) begin
      o_value_q <= o_value_d;
      o_sat_q   <= o_sat_d;
    end
  end

  assign valid_o = o_valid_q;
  assign value_o = o_value_q;
  assign sat_o   = o_sat_q;

endmodule

@@ rtl/nibble_weight_dot_product.sv @@
// Top level of the nibble-weight dot product: input stage, eight lanes,
// merging stage and scaling pipeline. Depends on nwdp_pkg, nwdp_lane,
// nwdp_merge and nwdp_scale.
//
// Usage: each input beat on s_axis carries eight signed Q8.8 activations and
// one word of eight 4-bit weights; s_axis_tlast marks the final chunk of a
// dot product. Every lane forms a_j * (2q_j - 15) and the merging stage adds
// the lanes into a 48-bit running sum. Only the beat with tlast set produces
// a result on m_axis: the sum times the Q4.12 scale, floor-shifted by 13,
// saturated to 32 bits, with the clip flag in m_axis_tuser. The running sum
// then restarts from zero.
// Throughput: one input beat per cycle; only a tlast beat waits on a stalled
// merge register. A result passes the input register, merge register,
// magnitude stage, partial product stage and output register in turn.
// The scale register is written by cfg_we_i/cfg_wdata_i and resets to 1.0.
// Reset clears the running sum and empties all stages. When the receiver
// stalls, the result holds in the output register and the stages behind it
// keep filling; non-last beats are still absorbed into the sum.
`timescale 1ns / 1ps

module nibble_weight_dot_product (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Scale register write port.
  input  logic                                  cfg_we_i,
  input  logic [nwdp_pkg::SCALE_BITS-1:0]       cfg_wdata_i,
  // Input stream.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: act_0 .. act_7 (16 bits each), weight_word (32 bits).
  input  logic [nwdp_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
  input  logic                                  s_axis_tlast,
  // Result stream.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // Fields from bit 0: dot_value (32 bits).
  output logic [nwdp_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
  // Fields from bit 0: saturated (1 bit).
  output logic                                  m_axis_tuser
);
  import nwdp_pkg::*;

  scale_t    scale_q;
  prod_t     prod    [LANES];
  prod_t     prod_q  [LANES];
  logic      in_valid_q, in_last_q;
  logic      merge_fire, scale_ready;
  sum_beat_t sum_beat;

  // Scale register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // Lanes work on the incoming beat directly.
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    nwdp_lane u_lane (
      .act_i  (act_t'(s_axis_tdata[j*ACT_BITS +: ACT_BITS])),
      .nib_i  (s_axis_tdata[LANES*ACT_BITS + j*NIB_BITS +: NIB_BITS]),
      .prod_o (prod[j])
    );
  end

  // Input stage register holding the lane products.
  assign s_axis_tready = !in_valid_q || merge_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      prod_q    <= prod;
      in_last_q <= s_axis_tlast;
    end
  end

  nwdp_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .prod_i  (prod_q),
    .valid_i (in_valid_q),
    .last_i  (in_last_q),
    .fire_o  (merge_fire),
    .beat_o  (sum_beat),
    .ready_i (scale_ready)
  );

  nwdp_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scale_i (scale_q),
    .beat_i  (sum_beat),
    .ready_o (scale_ready),
    .valid_o (m_axis_tvalid),
    .value_o (m_axis_tdata),
    .sat_o   (m_axis_tuser),
    .ready_i (m_axis_tready)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for nibble_weight_dot_product: a directed table, then random
// dot products checked against a cycle-free predictor or pins. Depends on nwdp_pkg.
`timescale 1ns / 1ps

module tb;
  import nwdp_pkg::*;

  localparam int ACTS_W    = LANES * ACT_BITS;
  localparam int LONG_RUN  = 110;
  localparam int HOLD_LEN  = 150;
  localparam int SETTLE    = 8;

  typedef struct packed {
    logic [OUT_BITS-1:0] dot;
    logic                sat;
  } dot_beat_t;

  typedef enum logic {ROW_BEAT, ROW_SCALE} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [ACTS_W-1:0]   acts;
    logic [WORD_BITS-1:0] word;
    bit                  last;
    bit                  pinned;
    logic [OUT_BITS-1:0] pin_dot;
    bit                  pin_sat;
    scale_t              scale;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  scale_t cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tuser;

  // A hand-typed expectation travels beside the beat it belongs to.
  logic pin_en = 1'b0;
  logic [OUT_BITS-1:0] pin_dot = '0;
  logic pin_sat = 1'b0;

  // Predictor state and the store of expected results.
  sum_t open_sum = '0;
  scale_t scale_copy = SCALE_RESET;
  dot_beat_t pending_dots[$];
  int mismatches = 0;

  // Flow control between the sender and the receiver.
  bit calm = 1'b0;
  int holds_asked = 0;
  int holds_granted = 0;

  always #1 clk_i = ~clk_i;

  nibble_weight_dot_product DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Sum of a_j * (2q_j - 15) over the eight lanes of one beat.
  function automatic sum_t chunk_sum(logic [IN_TDATA_BITS-1:0] d);
    sum_t acc;
    act_t a;
    nib_t q;
    acc = '0;
    for (int j = 0; j < LANES; j++) begin
      a = d[j*ACT_BITS +: ACT_BITS];
      q = d[ACTS_W + j*NIB_BITS +: NIB_BITS];
      acc = acc + sum_t'(int'(a) * (2 * int'(q) - WEIGHT_OFFSET));
    end
    return acc;
  endfunction

  // Full-width product with the scale, floor shift, then clip to 32 bits.
  function automatic dot_beat_t scaled_dot(sum_t s, scale_t k);
    logic signed [65:0] p;
    dot_beat_t r;
    p = s * $signed({1'b0, k});
    p = p >>> SCALE_SHIFT;
    if (p > 66'sh0_7FFF_FFFF) begin
      r = '{32'h7FFF_FFFF, 1'b1};
    end else if (p < -66'sh0_8000_0000) begin
      r = '{32'h8000_0000, 1'b1};
    end else begin
      r = '{p[OUT_BITS-1:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [ACTS_W-1:0] lanes(int a0, int a1, int a2, int a3,
                                              int a4, int a5, int a6, int a7);
    return {16'(a7), 16'(a6), 16'(a5), 16'(a4), 16'(a3), 16'(a2), 16'(a1), 16'(a0)};
  endfunction

  function automatic logic [ACTS_W-1:0] all_lanes(int a);
    return lanes(a, a, a, a, a, a, a, a);
  endfunction

  function automatic row_t beat_row(logic [ACTS_W-1:0] acts, logic [WORD_BITS-1:0] word,
                                    bit last, bit pinned = 1'b0, int dot = 0,
                                    bit sat = 1'b0);
    return '{ROW_BEAT, acts, word, last, pinned, OUT_BITS'(dot), sat, '0};
  endfunction

  function automatic row_t scale_row(scale_t v);
    return '{ROW_SCALE, '0, '0, 1'b0, 1'b0, '0, 1'b0, v};
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Prediction on every accepted input beat, checking on every accepted result beat.
  always @(posedge clk_i) begin : scoreboard
    sum_t total;
    dot_beat_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        scale_copy = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        total = open_sum + chunk_sum(s_axis_tdata);
        if (s_axis_tlast) begin
          want = pin_en ? dot_beat_t'{pin_dot, pin_sat} : scaled_dot(total, scale_copy);
          pending_dots.push_back(want);
          open_sum = '0;
        end else begin
          open_sum = total;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_dots.size() == 0) begin
          flag_mismatch($sformatf("result %h with nothing pending", m_axis_tdata));
        end else begin
          want = pending_dots.pop_front();
          if (m_axis_tdata !== want.dot) begin
            flag_mismatch($sformatf("dot_value %h, expected %h", m_axis_tdata, want.dot));
          end
          if (m_axis_tuser !== want.sat) begin
            flag_mismatch($sformatf("saturated %b, expected %b", m_axis_tuser, want.sat));
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold on request, none in the final phase.
  initial begin : receiver
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_granted != holds_asked) begin
        holds_granted++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offers one beat, possibly after a gap, and holds it until accepted.
  task automatic push_beat(logic [ACTS_W-1:0] acts, logic [WORD_BITS-1:0] word, bit last,
                           bit pinned = 1'b0, logic [OUT_BITS-1:0] dot = '0,
                           bit sat = 1'b0);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {word, acts};
    s_axis_tlast  <= last;
    pin_en        <= pinned;
    pin_dot       <= dot;
    pin_sat       <= sat;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops sending and waits until every expected result is back and the pipe is empty.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_dots.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_scale(scale_t v);
    wait_quiet();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic rand_beat(output logic [ACTS_W-1:0] acts, output logic [WORD_BITS-1:0] word);
    act_t a;
    for (int j = 0; j < LANES; j++) begin
      case ($urandom_range(0, 9))
        0:       a = 16'sh8000;
        1:       a = 16'sh7FFF;
        2:       a = '0;
        3:       a = '1;
        default: a = act_t'($urandom);
      endcase
      acts[j*ACT_BITS +: ACT_BITS] = a;
    end
    case ($urandom_range(0, 9))
      0:       word = '0;
      1:       word = '1;
      2:       word = 32'h8888_8888;
      3:       word = 32'h7777_7777;
      default: word = $urandom;
    endcase
  endtask

  // A long run of large, same-signed products that drives the result into the clip.
  task automatic long_run(bit up);
    logic [ACTS_W-1:0] acts;
    logic [WORD_BITS-1:0] mask;
    for (int i = 0; i < LONG_RUN; i++) begin
      for (int j = 0; j < LANES; j++) begin
        acts[j*ACT_BITS +: ACT_BITS] = ACT_BITS'($urandom_range(30000, 32767));
      end
      mask = $urandom & 32'h1111_1111;
      push_beat(acts, up ? ~mask : mask, i == LONG_RUN - 1);
    end
  endtask

  initial begin : stimulus
    row_t plan[$];
    logic [ACTS_W-1:0] acts;
    logic [WORD_BITS-1:0] word;
    scale_t sc;
    int n;
    int len;

    // Directed rows: zero, single lanes, all-lane extremes, rounding toward minus
    // infinity, every nibble value, multi-beat sums and the scale extremes.
    plan.push_back(beat_row(all_lanes(0), 32'h0, 1, 1, 0));
    plan.push_back(beat_row(lanes(256, 0, 0, 0, 0, 0, 0, 0), 32'h0000_000F, 1, 1, 1920));
    plan.push_back(beat_row(all_lanes(-32768), 32'h0, 1, 1, 1966080));
    plan.push_back(beat_row(all_lanes(32767), 32'hFFFF_FFFF, 1, 1, 1966020));
    plan.push_back(beat_row(all_lanes(32767), 32'h0, 1, 1, -1966020));
    plan.push_back(beat_row(all_lanes(-32768), 32'hFFFF_FFFF, 1, 1, -1966080));
    plan.push_back(beat_row(lanes(-1, 0, 0, 0, 0, 0, 0, 0), 32'h0000_0008, 1, 1, -1));
    plan.push_back(beat_row(lanes(1, 0, 0, 0, 0, 0, 0, 0), 32'h0000_0008, 1, 1, 0));
    plan.push_back(beat_row(lanes(0, 0, 0, 0, 0, 0, 0, 32767), 32'hF000_0000, 1, 1, 245752));
    plan.push_back(beat_row(lanes(100, -200, 300, -400, 500, -600, 700, -800),
                            32'h7654_3210, 0));
    plan.push_back(beat_row(lanes(-32768, 32767, -1, 1, 0, 256, -256, 12345),
                            32'hFEDC_BA98, 0));
    plan.push_back(beat_row(lanes(21845, -21846, 21845, -21846, 21845, -21846, 21845,
                                  -21846), 32'h5A5A_5A5A, 0));
    plan.push_back(beat_row(lanes(-21846, 21845, -21846, 21845, -21846, 21845, -21846,
                                  21845), 32'hA5A5_A5A5, 1));
    plan.push_back(scale_row(16'h0000));
    plan.push_back(beat_row(all_lanes(32767), 32'hFFFF_FFFF, 1, 1, 0));
    plan.push_back(scale_row(16'hFFFF));
    plan.push_back(beat_row(all_lanes(32767), 32'hFFFF_FFFF, 0));
    plan.push_back(beat_row(all_lanes(-32768), 32'h0, 1));
    plan.push_back(scale_row(16'h0001));
    plan.push_back(beat_row(all_lanes(32767), 32'hFFFF_FFFF, 1, 1, 479));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SCALE) begin
        write_scale(plan[i].scale);
      end else begin
        push_beat(plan[i].acts, plan[i].word, plan[i].last, plan[i].pinned,
                  plan[i].pin_dot, plan[i].pin_sat);
      end
    end

    // Random phases, each under its own scale; the last phase runs without idling.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       sc = SCALE_RESET;
        1:       sc = 16'hFFFF;
        2:       sc = 16'h0000;
        3:       sc = 16'h0001;
        5:       sc = 16'h8000;
        7:       sc = 16'hFFFF;
        default: sc = scale_t'($urandom);
      endcase
      write_scale(sc);
      calm = (ph == 7);
      if (ph == 1) begin
        long_run(1'b1);
        long_run(1'b0);
      end
      // Single-beat dot products against a long receiver hold fill the pipe.
      if (ph == 5) begin
        holds_asked++;
      end
      n = 0;
      while (n < 28) begin
        len = (ph == 5) ? 1 : $urandom_range(1, 6);
        for (int k = 1; k <= len; k++) begin
          rand_beat(acts, word);
          push_beat(acts, word, k == len);
        end
        n += len;
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
